// ----- rtl/llp_pkg.sv -----
package llp_pkg;

  localparam int POOL_NODES  = 256;
  localparam int VALUE_BITS  = 32;
  localparam int HANDLE_BITS = $clog2(POOL_NODES + 1);
  localparam int ADDR_BITS   = $clog2(POOL_NODES);
  localparam int KIND_BITS   = 3;
  localparam int STATUS_BITS = 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // stream widths, padded to whole bytes
  localparam int IN_DATA_BITS  = ((VALUE_BITS + HANDLE_BITS + 7) / 8) * 8;
  localparam int OUT_RAW_BITS  = 2 * HANDLE_BITS + VALUE_BITS;
  localparam int OUT_DATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;

  typedef logic [HANDLE_BITS-1:0] handle_t;
  typedef logic [VALUE_BITS-1:0]  value_t;
  typedef logic [ADDR_BITS-1:0]   addr_t;
  typedef logic [STATUS_BITS-1:0] status_t;

  // command kinds on the input stream
  localparam logic [KIND_BITS-1:0] KIND_PREPEND    = 3'd0;
  localparam logic [KIND_BITS-1:0] KIND_APPEND     = 3'd1;
  localparam logic [KIND_BITS-1:0] KIND_FREE_FIRST = 3'd2;
  localparam logic [KIND_BITS-1:0] KIND_FREE_ALL   = 3'd3;
  localparam logic [KIND_BITS-1:0] KIND_READ_NODE  = 3'd4;

  // result status codes
  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_FULL = 2'd1;
  localparam status_t ST_BAD  = 2'd2;

  typedef enum logic [2:0] {
    OP_PREPEND,
    OP_APPEND,
    OP_FREE_FIRST,
    OP_FREE_ALL,
    OP_READ,
    OP_BAD
  } op_t;

  typedef struct packed {
    op_t     op;
    value_t  value;
    handle_t handle;
  } cmd_t;

  typedef struct packed {
    handle_t handle;
    value_t  value;
    handle_t link;
    status_t status;
  } result_t;

  // handle 1..POOL_NODES maps onto memory row 0..POOL_NODES-1
  function automatic addr_t to_addr(handle_t h);
    handle_t d;
    d = h - handle_t'(1);
    return d[ADDR_BITS-1:0];
  endfunction

endpackage

// ----- rtl/linked_list_pool_manager.sv -----
// Sequencing: a front insert, free_first, read_node and an append onto an empty list finish in
// S_EXEC; an append onto a list walks the links in S_WALK, takes a node in S_TAKE and, unless
// it lay on the path, links it in S_PB_LINK; free_all frees node by node in S_FREE (an empty
// or invalid head finishes in S_EXEC). Throughput: one item at a time; the next item starts
// as the result leaves. A 2-entry input queue and the result register let each side stall
// alone. Synchronous reset empties the pool at once.
module linked_list_pool_manager (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // item_value [31:0], handle_in [40:32], zero pad
  input  logic [llp_pkg::IN_DATA_BITS-1:0]     s_tdata,
  // kind [2:0]
  input  logic [llp_pkg::KIND_BITS-1:0]        s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // handle_out [8:0], node_value [40:9], node_link [49:41], zero pad
  output logic [llp_pkg::OUT_DATA_BITS-1:0]    m_tdata,
  // status [1:0]
  output logic [llp_pkg::STATUS_BITS-1:0]      m_tuser
);

  logic             cmd_valid;
  logic             cmd_pop;
  llp_pkg::cmd_t    cmd;
  llp_pkg::result_t res;

  llp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop)
  );

  llp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop),
    .res_valid(m_tvalid),
    .res      (res),
    .res_ready(m_tready)
  );

  // pack the result fields
  assign m_tdata = llp_pkg::OUT_DATA_BITS'({res.link, res.value, res.handle});
  assign m_tuser = res.status;

endmodule

// ----- rtl/llp_front.sv -----
module llp_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [llp_pkg::IN_DATA_BITS-1:0]    s_tdata,
  input  logic [llp_pkg::KIND_BITS-1:0]       s_tuser,
  output logic                                cmd_valid,
  output llp_pkg::cmd_t                       cmd,
  input  logic                                cmd_pop
);

  llp_pkg::cmd_t                      queue [llp_pkg::QUEUE_DEPTH];
  logic [llp_pkg::QPTR_BITS-1:0]      wr_ptr;
  logic [llp_pkg::QPTR_BITS-1:0]      rd_ptr;
  logic [llp_pkg::QCNT_BITS-1:0]      count;
  logic                               push;
  logic                               pop;
  llp_pkg::cmd_t                      in_cmd;

  // map the kind code onto an operation
  function automatic llp_pkg::op_t decode(logic [llp_pkg::KIND_BITS-1:0] k);
    llp_pkg::op_t o;
    case (k)
      llp_pkg::KIND_PREPEND:    o = llp_pkg::OP_PREPEND;
      llp_pkg::KIND_APPEND:     o = llp_pkg::OP_APPEND;
      llp_pkg::KIND_FREE_FIRST: o = llp_pkg::OP_FREE_FIRST;
      llp_pkg::KIND_FREE_ALL:   o = llp_pkg::OP_FREE_ALL;
      llp_pkg::KIND_READ_NODE:  o = llp_pkg::OP_READ;
      default:                  o = llp_pkg::OP_BAD;
    endcase
    return o;
  endfunction

  // classify the incoming item
  always_comb begin
    in_cmd.op     = decode(s_tuser);
    in_cmd.value  = s_tdata[llp_pkg::VALUE_BITS-1:0];
    in_cmd.handle = s_tdata[llp_pkg::VALUE_BITS +: llp_pkg::HANDLE_BITS];
  end

  assign s_tready  = (count != llp_pkg::QCNT_BITS'(llp_pkg::QUEUE_DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = queue[rd_ptr];
  assign push      = s_tvalid && s_tready;
  assign pop       = cmd_pop && cmd_valid;

  // hold items until the back end takes them
  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/llp_back.sv -----
module llp_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  llp_pkg::cmd_t     cmd,
  output logic              cmd_pop,
  output logic              res_valid,
  output llp_pkg::result_t  res,
  input  logic              res_ready
);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_EXEC    = 7'b0000010,
    S_WALK    = 7'b0000100,
    S_TAKE    = 7'b0001000,
    S_PB_LINK = 7'b0010000,
    S_FREE    = 7'b0100000,
    S_SPARE   = 7'b1000000
  } state_t;

  localparam llp_pkg::handle_t POOL_LIMIT = llp_pkg::HANDLE_BITS'(llp_pkg::POOL_NODES);
  localparam llp_pkg::addr_t   STEP_LAST  = llp_pkg::ADDR_BITS'(llp_pkg::POOL_NODES - 1);

  state_t state, state_next;

  llp_pkg::op_t     c_op;
  llp_pkg::value_t  c_value;
  llp_pkg::handle_t c_h;
  logic             load_cmd;

  llp_pkg::handle_t free_head, free_head_next;
  llp_pkg::handle_t slots_used, slots_used_next;
  llp_pkg::handle_t cur, cur_next;
  llp_pkg::addr_t   steps, steps_next;
  llp_pkg::handle_t cnt, cnt_next;
  llp_pkg::handle_t tail, tail_next;
  logic             seen, seen_next;
  llp_pkg::handle_t new_node, new_node_next;

  // node storage
  llp_pkg::value_t  value_mem [llp_pkg::POOL_NODES];
  llp_pkg::handle_t link_mem  [llp_pkg::POOL_NODES];
  llp_pkg::addr_t   rd_addr;
  llp_pkg::value_t  value_q;
  llp_pkg::handle_t link_q;
  logic             fwd_hit;
  llp_pkg::handle_t fwd_data;
  llp_pkg::handle_t link_rd;
  logic             lwr_en;
  llp_pkg::addr_t   lwr_addr;
  llp_pkg::handle_t lwr_data;
  logic             vwr_en;
  llp_pkg::addr_t   vwr_addr;

  logic             res_load;
  llp_pkg::result_t res_next;

  logic             fh_ok;
  logic             full;
  llp_pkg::handle_t fresh;
  llp_pkg::handle_t take_n;
  logic             seen_now;
  logic             read_free_head;

  function automatic logic hok(llp_pkg::handle_t h, llp_pkg::handle_t used);
    return (h != '0) && (h <= used);
  endfunction

  assign fh_ok   = hok(free_head, slots_used);
  assign full    = !fh_ok && (slots_used >= POOL_LIMIT);
  assign fresh   = slots_used + 1'b1;
  assign take_n  = fh_ok ? free_head : fresh;
  assign link_rd = fwd_hit ? fwd_data : link_q;
  assign seen_now = seen || (cur == new_node);
  assign read_free_head = (cmd.op == llp_pkg::OP_PREPEND) ||
                          ((cmd.op == llp_pkg::OP_APPEND) && (cmd.handle == '0));

  // memories: one write, one registered read; forward a same-cycle link write
  always_ff @(posedge clk) begin
    if (lwr_en) begin
      link_mem[lwr_addr] <= lwr_data;
    end
    if (vwr_en) begin
      value_mem[vwr_addr] <= c_value;
    end
    link_q   <= link_mem[rd_addr];
    value_q  <= value_mem[rd_addr];
    fwd_hit  <= lwr_en && (lwr_addr == rd_addr);
    fwd_data <= lwr_data;
  end

  // sequence each command
  always_comb begin
    state_next      = state;
    load_cmd        = 1'b0;
    cmd_pop         = 1'b0;
    rd_addr         = llp_pkg::to_addr(c_h);
    lwr_en          = 1'b0;
    lwr_addr        = llp_pkg::to_addr(cur);
    lwr_data        = '0;
    vwr_en          = 1'b0;
    vwr_addr        = llp_pkg::to_addr(new_node);
    res_load        = 1'b0;
    res_next        = '0;
    free_head_next  = free_head;
    slots_used_next = slots_used;
    cur_next        = cur;
    steps_next      = steps;
    cnt_next        = cnt;
    tail_next       = tail;
    seen_next       = seen;
    new_node_next   = new_node;

    case (state)
      // take the next item once no result waits or as the waiting result leaves
      S_IDLE: begin
        if (cmd_valid && (!res_valid || res_ready)) begin
          cmd_pop    = 1'b1;
          load_cmd   = 1'b1;
          rd_addr    = read_free_head ? llp_pkg::to_addr(free_head)
                                      : llp_pkg::to_addr(cmd.handle);
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        case (c_op)
          llp_pkg::OP_PREPEND, llp_pkg::OP_APPEND: begin
            if ((c_h != '0) && !hok(c_h, slots_used)) begin
              res_load        = 1'b1;
              res_next.status = llp_pkg::ST_BAD;
            end else if (full) begin
              res_load        = 1'b1;
              res_next.status = llp_pkg::ST_FULL;
            end else if ((c_op == llp_pkg::OP_PREPEND) || (c_h == '0)) begin
              // take a node and link it in front
              if (fh_ok) begin
                free_head_next = link_rd;
              end else begin
                slots_used_next = fresh;
              end
              vwr_en          = 1'b1;
              vwr_addr        = llp_pkg::to_addr(take_n);
              lwr_en          = 1'b1;
              lwr_addr        = llp_pkg::to_addr(take_n);
              lwr_data        = c_h;
              res_load        = 1'b1;
              res_next.handle = take_n;
              res_next.status = llp_pkg::ST_OK;
            end else begin
              // walk to the tail first
              cur_next      = c_h;
              steps_next    = '0;
              seen_next     = 1'b0;
              new_node_next = take_n;
              rd_addr       = llp_pkg::to_addr(c_h);
              state_next    = S_WALK;
            end
          end
          llp_pkg::OP_FREE_FIRST: begin
            res_load = 1'b1;
            if (c_h == '0) begin
              res_next.status = llp_pkg::ST_OK;
            end else if (!hok(c_h, slots_used)) begin
              res_next.status = llp_pkg::ST_BAD;
            end else begin
              lwr_en          = 1'b1;
              lwr_addr        = llp_pkg::to_addr(c_h);
              lwr_data        = free_head;
              free_head_next  = c_h;
              res_next.handle = link_rd;
              res_next.status = llp_pkg::ST_OK;
            end
          end
          llp_pkg::OP_FREE_ALL: begin
            if (c_h == '0) begin
              res_load        = 1'b1;
              res_next.status = llp_pkg::ST_OK;
            end else if (!hok(c_h, slots_used)) begin
              res_load        = 1'b1;
              res_next.status = llp_pkg::ST_BAD;
            end else begin
              cur_next   = c_h;
              cnt_next   = '0;
              rd_addr    = llp_pkg::to_addr(c_h);
              state_next = S_FREE;
            end
          end
          llp_pkg::OP_READ: begin
            res_load = 1'b1;
            if (hok(c_h, slots_used)) begin
              res_next.value  = value_q;
              res_next.link   = link_rd;
              res_next.status = llp_pkg::ST_OK;
            end else begin
              res_next.status = llp_pkg::ST_BAD;
            end
          end
          default: begin
            res_load        = 1'b1;
            res_next.status = llp_pkg::ST_BAD;
          end
        endcase
        if (res_load) begin
          state_next = S_IDLE;
        end
      end

      // one link per cycle; note whether the node to take lies on the path
      S_WALK: begin
        if (link_rd == '0) begin
          tail_next  = cur;
          seen_next  = seen_now;
          rd_addr    = llp_pkg::to_addr(free_head);
          state_next = S_TAKE;
        end else if (!hok(link_rd, slots_used) || (steps == STEP_LAST)) begin
          res_load        = 1'b1;
          res_next.status = llp_pkg::ST_BAD;
          state_next      = S_IDLE;
        end else begin
          cur_next   = link_rd;
          steps_next = steps + 1'b1;
          seen_next  = seen_now;
          rd_addr    = llp_pkg::to_addr(link_rd);
        end
      end

      // take the node; if it sat on the path it becomes the tail itself
      S_TAKE: begin
        if (fh_ok) begin
          free_head_next = link_rd;
        end else begin
          slots_used_next = fresh;
        end
        vwr_en   = 1'b1;
        lwr_en   = 1'b1;
        lwr_addr = llp_pkg::to_addr(new_node);
        lwr_data = seen ? new_node : '0;
        if (seen) begin
          res_load        = 1'b1;
          res_next.handle = c_h;
          res_next.status = llp_pkg::ST_OK;
          state_next      = S_IDLE;
        end else begin
          state_next = S_PB_LINK;
        end
      end

      S_PB_LINK: begin
        lwr_en          = 1'b1;
        lwr_addr        = llp_pkg::to_addr(tail);
        lwr_data        = new_node;
        res_load        = 1'b1;
        res_next.handle = c_h;
        res_next.status = llp_pkg::ST_OK;
        state_next      = S_IDLE;
      end

      // free one node per cycle onto the free list
      S_FREE: begin
        if ((cur == '0) || (cnt == POOL_LIMIT) || !hok(cur, slots_used)) begin
          res_load        = 1'b1;
          res_next.handle = cur;
          res_next.status = (cur != '0) ? llp_pkg::ST_BAD : llp_pkg::ST_OK;
          state_next      = S_IDLE;
        end else begin
          lwr_en         = 1'b1;
          lwr_addr       = llp_pkg::to_addr(cur);
          lwr_data       = free_head;
          free_head_next = cur;
          cur_next       = link_rd;
          cnt_next       = cnt + 1'b1;
          rd_addr        = llp_pkg::to_addr(link_rd);
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // command and walk registers
  always_ff @(posedge clk) begin
    if (load_cmd) begin
      c_op    <= cmd.op;
      c_value <= cmd.value;
      c_h     <= cmd.handle;
    end
    cur      <= cur_next;
    steps    <= steps_next;
    cnt      <= cnt_next;
    tail     <= tail_next;
    seen     <= seen_next;
    new_node <= new_node_next;
    if (res_load) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      free_head  <= '0;
      slots_used <= '0;
      res_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      free_head  <= free_head_next;
      slots_used <= slots_used_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  a_slots_bound: assert property (@(posedge clk) disable iff (rst)
    slots_used <= POOL_LIMIT)
    else $error("slot count beyond pool size");

  a_free_head_valid: assert property (@(posedge clk) disable iff (rst)
    (free_head == '0) || (free_head <= slots_used))
    else $error("free list head points past used slots");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    res_load |=> res_valid && (state == S_IDLE))
    else $error("result not registered on finish");

  a_walk_append: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (c_op == llp_pkg::OP_APPEND) && (c_h != '0))
    else $error("walk entered for wrong command");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> (state == S_IDLE) && (!res_valid || res_ready))
    else $error("command taken while busy");

endmodule

// ----- sim/testbench.sv -----
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_ITEMS   = 1050;

  typedef struct {
    llp_pkg::handle_t handle;
    llp_pkg::value_t  value;
    llp_pkg::handle_t link;
    llp_pkg::status_t status;
  } llp_result_t;

  // Pool predictor and the queue of results it has worked out
  class pool_scoreboard;
    llp_pkg::value_t  values[llp_pkg::POOL_NODES + 1];
    llp_pkg::handle_t links[llp_pkg::POOL_NODES + 1];
    int unsigned      free_head;
    int unsigned      used;
    llp_result_t      pending[$];
    int               errors;
    int               checked;

    function void clear();
      free_head = 0;
      used = 0;
      pending.delete();
      errors = 0;
      checked = 0;
      foreach (links[i]) begin
        links[i] = '0;
        values[i] = '0;
      end
    endfunction

    function bit valid_handle(int unsigned h);
      return h >= 1 && h <= used;
    endfunction

    function bit pool_exhausted();
      return !(free_head != 0 && valid_handle(free_head)) && used >= llp_pkg::POOL_NODES;
    endfunction

    function int unsigned locate_tail(int unsigned head);
      int unsigned cur;
      int unsigned nx;
      cur = head;
      for (int s = 0; s < llp_pkg::POOL_NODES; s++) begin
        nx = links[cur];
        if (nx == 0) return cur;
        if (!valid_handle(nx)) return 0;
        cur = nx;
      end
      return 0;
    endfunction

    function int unsigned grab_node();
      int unsigned n;
      if (free_head != 0 && valid_handle(free_head)) begin
        n = free_head;
        free_head = links[n];
        return n;
      end
      used++;
      return used;
    endfunction

    function int unsigned release_node(int unsigned x);
      int unsigned rest;
      rest = links[x];
      links[x] = llp_pkg::handle_t'(free_head);
      free_head = x;
      return rest;
    endfunction

    // Apply one command and queue its result
    function void note_command(logic [llp_pkg::KIND_BITS-1:0] kind, llp_pkg::value_t val,
                               llp_pkg::handle_t hin);
      llp_result_t r;
      int unsigned h;
      int unsigned n;
      int unsigned t;
      int unsigned cur;
      h = hin;
      r = '{handle: '0, value: '0, link: '0, status: llp_pkg::ST_OK};
      case (kind)
        llp_pkg::KIND_PREPEND, llp_pkg::KIND_APPEND: begin
          if (h != 0 && !valid_handle(h)) r.status = llp_pkg::ST_BAD;
          else if (pool_exhausted()) r.status = llp_pkg::ST_FULL;
          else if (kind == llp_pkg::KIND_PREPEND) begin
            n = grab_node();
            values[n] = val;
            links[n] = llp_pkg::handle_t'(h);
            r.handle = llp_pkg::handle_t'(n);
          end else if (h != 0 && locate_tail(h) == 0) r.status = llp_pkg::ST_BAD;
          else begin
            n = grab_node();
            values[n] = val;
            links[n] = '0;
            if (h == 0) r.handle = llp_pkg::handle_t'(n);
            else begin
              t = locate_tail(h);
              if (t != 0) links[t] = llp_pkg::handle_t'(n);
              r.handle = llp_pkg::handle_t'(h);
            end
          end
        end
        llp_pkg::KIND_FREE_FIRST: begin
          if (h != 0) begin
            if (!valid_handle(h)) r.status = llp_pkg::ST_BAD;
            else r.handle = llp_pkg::handle_t'(release_node(h));
          end
        end
        llp_pkg::KIND_FREE_ALL: begin
          if (h != 0) begin
            if (!valid_handle(h)) r.status = llp_pkg::ST_BAD;
            else begin
              cur = h;
              for (int c = 0; c < llp_pkg::POOL_NODES && cur != 0; c++) begin
                if (!valid_handle(cur)) break;
                cur = release_node(cur);
              end
              r.handle = llp_pkg::handle_t'(cur);
              if (cur != 0) r.status = llp_pkg::ST_BAD;
            end
          end
        end
        llp_pkg::KIND_READ_NODE: begin
          if (!valid_handle(h)) r.status = llp_pkg::ST_BAD;
          else begin
            r.value = values[h];
            r.link = links[h];
          end
        end
        default: r.status = llp_pkg::ST_BAD;
      endcase
      pending = {pending, r};
    endfunction

    task report(string what, longint got, longint want);
      $display("mismatch on result %0d: %s got %0h expected %0h", checked, what, got, want);
      errors++;
    endtask

    // Compare one result with the oldest expectation
    task check_result(llp_result_t got);
      llp_result_t want;
      if (pending.size() == 0) begin
        $display("result %0d arrived with nothing expected", checked);
        errors++;
        checked++;
        return;
      end
      want = pending.pop_front();
      if (got.handle !== want.handle) report("handle_out", got.handle, want.handle);
      if (got.value !== want.value) report("node_value", got.value, want.value);
      if (got.link !== want.link) report("node_link", got.link, want.link);
      if (got.status !== want.status) report("status", got.status, want.status);
      checked++;
    endtask
  endclass

  logic                              clk;
  logic                              rst;
  logic                              s_tvalid;
  logic                              s_tready;
  logic [llp_pkg::IN_DATA_BITS-1:0]  s_tdata;
  logic [llp_pkg::KIND_BITS-1:0]     s_tuser;
  logic                              m_tvalid;
  logic                              m_tready;
  logic [llp_pkg::OUT_DATA_BITS-1:0] m_tdata;
  logic [llp_pkg::STATUS_BITS-1:0]   m_tuser;

  pool_scoreboard board;
  bit             calm;
  bit             hold_sink;
  int             idle_cycles;
  int             sent;
  int             kind_seen[8];

  linked_list_pool_manager dut (.*);

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Send one command, with a random gap before it unless calm
  task automatic send_command(logic [llp_pkg::KIND_BITS-1:0] kind, llp_pkg::value_t val,
                              llp_pkg::handle_t h);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= llp_pkg::IN_DATA_BITS'({h, val});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_command(kind, val, h);
    kind_seen[kind]++;
    sent++;
    @(negedge clk);
  endtask

  // Wait until every expected result has come
  task automatic drain();
    s_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  // Pick a handle: mostly valid, sometimes empty or out of range
  function automatic llp_pkg::handle_t pick_handle();
    int unsigned p;
    p = $urandom_range(0, 19);
    if (p == 0) return '0;
    if (p == 1) return llp_pkg::handle_t'($urandom_range(0, llp_pkg::POOL_NODES));
    if (p == 2) return llp_pkg::handle_t'($urandom_range(0, 511));
    if (board.used == 0) return '0;
    return llp_pkg::handle_t'($urandom_range(1, board.used));
  endfunction

  // Receiver: random stalls, and a long hold-off on request
  always @(negedge clk) begin
    if (rst) m_tready <= 1'b0;
    else if (hold_sink) m_tready <= 1'b0;
    else if (calm) m_tready <= 1'b1;
    else if (idle_cycles > 0) begin
      m_tready <= 1'b0;
      idle_cycles <= idle_cycles - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      m_tready <= 1'b0;
      idle_cycles <= $urandom_range(0, 10);
    end else m_tready <= 1'b1;
  end

  // Check results and guard against a hang
  int stuck;
  always @(posedge clk) begin
    if (rst) stuck <= 0;
    else begin
      if (m_tvalid && m_tready) begin
        board.check_result('{handle: m_tdata[8:0], value: m_tdata[40:9],
                             link: m_tdata[49:41], status: m_tuser});
      end
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) stuck <= 0;
      else stuck <= stuck + 1;
      if (stuck >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    logic [llp_pkg::KIND_BITS-1:0] k;
    llp_pkg::handle_t              list_a;
    board = new();
    board.clear();
    calm = 1'b0;
    hold_sink = 1'b0;
    idle_cycles = 0;
    sent = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // Directed: empty frees, bad handles, every kind, unknown kinds, value extremes
    send_command(llp_pkg::KIND_FREE_FIRST, '0, '0);
    send_command(llp_pkg::KIND_FREE_ALL, '0, '0);
    send_command(llp_pkg::KIND_READ_NODE, '0, '0);
    send_command(llp_pkg::KIND_READ_NODE, '1, llp_pkg::handle_t'(llp_pkg::POOL_NODES));
    send_command(llp_pkg::KIND_PREPEND, '1, '0);
    send_command(llp_pkg::KIND_APPEND, '0, 9'd1);
    send_command(llp_pkg::KIND_APPEND, 32'h5555_AAAA, 9'd1);
    send_command(llp_pkg::KIND_PREPEND, 32'hAAAA_5555, 9'd1);
    send_command(llp_pkg::KIND_READ_NODE, '0, 9'd4);
    send_command(llp_pkg::KIND_APPEND, '1, 9'd511);
    send_command(3'd5, '0, 9'd1);
    send_command(3'd6, '1, 9'd2);
    send_command(3'd7, '0, 9'd3);
    send_command(llp_pkg::KIND_FREE_FIRST, '0, 9'd4);
    send_command(llp_pkg::KIND_PREPEND, 32'h1234_5678, '0);
    send_command(llp_pkg::KIND_FREE_ALL, '0, 9'd1);
    send_command(llp_pkg::KIND_APPEND, 32'h8000_0001, '0);
    // stale handle: free_first then insert onto the freed node forms a cycle
    send_command(llp_pkg::KIND_FREE_FIRST, '0, 9'd1);
    send_command(llp_pkg::KIND_PREPEND, 32'hDEAD_BEEF, 9'd1);
    send_command(llp_pkg::KIND_APPEND, 32'h0F0F_0F0F, 9'd1);
    send_command(llp_pkg::KIND_FREE_ALL, '0, 9'd1);
    send_command(llp_pkg::KIND_READ_NODE, '0, 9'd2);

    // Receiver holds off while the sender keeps offering
    fork
      begin
        hold_sink = 1'b1;
        repeat (60) @(negedge clk);
        hold_sink = 1'b0;
      end
      for (int i = 0; i < 8; i++) send_command(llp_pkg::KIND_PREPEND, $urandom, '0);
    join
    drain();

    // Fill the pool to hit pool_full
    list_a = '0;
    for (int i = 0; i < llp_pkg::POOL_NODES + 4 && sent < 400; i++) begin
      send_command(llp_pkg::KIND_PREPEND, $urandom, list_a);
      list_a = board.pending[$].handle;
    end
    send_command(llp_pkg::KIND_APPEND, '1, '0);
    drain();

    // Random mix of well-formed work and noise
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i > RANDOM_ITEMS - 200) calm = 1'b1;
      if (i == 500) drain();
      case ($urandom_range(0, 9))
        0, 1, 2: k = llp_pkg::KIND_PREPEND;
        3, 4: k = llp_pkg::KIND_APPEND;
        5: k = llp_pkg::KIND_FREE_FIRST;
        6: k = ($urandom_range(0, 3) == 0) ? llp_pkg::KIND_FREE_ALL : llp_pkg::KIND_READ_NODE;
        7, 8: k = llp_pkg::KIND_READ_NODE;
        default: k = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(5, 7))
                                                 : llp_pkg::KIND_FREE_ALL;
      endcase
      send_command(k, $urandom, pick_handle());
    end
    drain();

    $display("sent %0d commands, checked %0d results", sent, board.checked);
    $display("by kind: pf %0d pb %0d ff %0d fa %0d rd %0d other %0d",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4],
             kind_seen[5] + kind_seen[6] + kind_seen[7]);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
